// ===== sv/packed_binary_cross_erosion_core_macros.svh =====
// Assertion macros for the packed binary cross erosion core.
// Expects signals named clk and rst in the including scope.
`ifndef PACKED_BINARY_CROSS_EROSION_CORE_MACROS_SVH
`define PACKED_BINARY_CROSS_EROSION_CORE_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define PBCE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define PBCE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pbce_pkg.sv =====
// Shared types and constants for the packed binary cross erosion core.
// No dependencies.
`timescale 1ns / 1ps

package pbce_pkg;

  localparam int BYTE_W      = 8;
  localparam int ROW_OUT_W   = 12;
  localparam int COL_OUT_W   = 8;
  localparam int ROW_BYTES_W = 9;
  localparam int ROW_COUNT_W = 13;
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b1;

  localparam int ROW_BYTES_RST = 256;
  localparam int ROW_COUNT_RST = 4096;

  // Result queue: power-of-two depth, two writes per cycle at most.
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PW    = 2;

  typedef struct packed {
    logic [BYTE_W-1:0]    eroded_byte;
    logic [ROW_OUT_W-1:0] out_row;
    logic [COL_OUT_W-1:0] out_col;
    logic                 run_last;
    logic                 frame_done;
  } res_t;

  // Up to two results caused by one request, in delivery order.
  typedef struct packed {
    logic a_valid;
    res_t a;
    logic b_valid;
    res_t b;
  } pair_t;

endpackage

// ===== sv/packed_binary_cross_erosion_core.sv =====
// Packed binary cross erosion core: plus-shaped 3x3 erosion on a raster stream of packed bytes.
// A request's results enter the result queue at its accepting edge. Throughput: one request
// per cycle unless stalled; last-row requests can cause two results, so the single result
// port (one result a cycle) sets the rate there. Line buffers are shift chains of cells.
// Reset (rst, synchronous): clears position, left byte, queue; resets config; no clearing pass.
// Depends on pbce_pkg, pbce_cell, pbce_oq and the assertion macro header.
`timescale 1ns / 1ps
`include "packed_binary_cross_erosion_core_macros.svh"

module packed_binary_cross_erosion_core import pbce_pkg::*; #(
  parameter int MAX_ROW_BYTES = 256,
  parameter int MAX_ROWS      = 4096
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  // pixel request channel
  input  logic                   pixel_valid,
  output logic                   pixel_stall,
  input  logic [BYTE_W-1:0]      pixel_byte,
  // result channel
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [BYTE_W-1:0]      eroded_byte,
  output logic [ROW_OUT_W-1:0]   out_row,
  output logic [COL_OUT_W-1:0]   out_col,
  output logic                   run_last,
  output logic                   frame_done
);

  localparam int CW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int WW = (CW + 1 > ROW_BYTES_W) ? CW + 1 : ROW_BYTES_W;
  localparam int HW = (RW + 1 > ROW_COUNT_W) ? RW + 1 : ROW_COUNT_W;
  localparam int W_RST = (ROW_BYTES_RST > MAX_ROW_BYTES) ? MAX_ROW_BYTES : ROW_BYTES_RST;
  localparam int H_RST = (ROW_COUNT_RST > MAX_ROWS) ? MAX_ROWS : ROW_COUNT_RST;

  // Configuration, held as last column and last row after clamping.
  logic [CW-1:0]     w_m1;
  logic [RW-1:0]     h_m1;
  logic [CW-1:0]     w_m1_new;
  logic [RW-1:0]     h_m1_new;
  logic [WW-1:0]     rb_w;
  logic [HW-1:0]     rc_w;

  // Position of the next request and the middle-row byte left of it.
  logic [CW-1:0]     col;
  logic [CW-1:0]     col_next;
  logic [RW-1:0]     row;
  logic [RW-1:0]     row_next;
  logic [BYTE_W-1:0] left;
  logic [BYTE_W-1:0] left_next;

  // Line buffer chains: cell 0 is the head, data enters at cell w_m1.
  logic [BYTE_W-1:0] mchain [MAX_ROW_BYTES];
  logic [BYTE_W-1:0] uchain [MAX_ROW_BYTES];
  logic [MAX_ROW_BYTES-1:0] entry;

  logic              accept;
  logic              room;
  logic              at_row_end;
  logic              last_row;
  logic [BYTE_W-1:0] mid;
  logic [BYTE_W-1:0] up;
  logic [BYTE_W-1:0] right;
  logic              left_px;
  logic [BYTE_W-1:0] eroded;
  pair_t             pair;
  res_t              head;

  // ---------------------------------------------------------------------------
  // Configuration: clamp the written value into the supported range.
  // A zero width or height acts as one; anything above the maximum saturates.
  // ---------------------------------------------------------------------------
  always_comb begin
    rb_w = WW'(cfg_data[ROW_BYTES_W-1:0]);
    rc_w = HW'(cfg_data[ROW_COUNT_W-1:0]);
    if (rb_w == '0) begin
      w_m1_new = '0;
    end else if (rb_w > WW'(MAX_ROW_BYTES)) begin
      w_m1_new = CW'(MAX_ROW_BYTES - 1);
    end else begin
      w_m1_new = CW'(rb_w - WW'(1));
    end
    if (rc_w == '0) begin
      h_m1_new = '0;
    end else if (rc_w > HW'(MAX_ROWS)) begin
      h_m1_new = RW'(MAX_ROWS - 1);
    end else begin
      h_m1_new = RW'(rc_w - HW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_m1 <= CW'(W_RST - 1);
      h_m1 <= RW'(H_RST - 1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_BYTES: w_m1 <= w_m1_new;
        REG_ROW_COUNT: h_m1 <= h_m1_new;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Request handshake: take a request whenever the queue has room for two.
  // ---------------------------------------------------------------------------
  assign pixel_stall = !room;
  assign accept      = pixel_valid && !pixel_stall;

  // ---------------------------------------------------------------------------
  // Line buffers. Each accepted byte shifts both chains one cell toward the head.
  // After W shifts a byte sits at the middle chain head, one row old; it then
  // moves into the upper chain and shows at its head one row later. The cell
  // behind the middle head holds the right neighbor in the previous row.
  // ---------------------------------------------------------------------------
  assign mid = mchain[0];
  assign up  = uchain[0];

  for (genvar gi = 0; gi < MAX_ROW_BYTES; gi++) begin : g_col
    assign entry[gi] = (w_m1 == CW'(gi));
    if (gi == MAX_ROW_BYTES - 1) begin : g_tail
      pbce_cell u_mid (
        .clk   (clk),
        .shift (accept),
        .entry (entry[gi]),
        .din   (pixel_byte),
        .nbr   (pixel_byte),
        .q     (mchain[gi])
      );
      pbce_cell u_up (
        .clk   (clk),
        .shift (accept),
        .entry (entry[gi]),
        .din   (mid),
        .nbr   (mid),
        .q     (uchain[gi])
      );
    end else begin : g_body
      pbce_cell u_mid (
        .clk   (clk),
        .shift (accept),
        .entry (entry[gi]),
        .din   (pixel_byte),
        .nbr   (mchain[gi+1]),
        .q     (mchain[gi])
      );
      pbce_cell u_up (
        .clk   (clk),
        .shift (accept),
        .entry (entry[gi]),
        .din   (mid),
        .nbr   (uchain[gi+1]),
        .q     (uchain[gi])
      );
    end
  end

  // ---------------------------------------------------------------------------
  // Erosion of the middle row byte. Pixels beyond the row ends count as clear.
  // ---------------------------------------------------------------------------
  assign at_row_end = (col == w_m1);
  assign last_row   = (row == h_m1);
  assign right      = at_row_end ? '0 : mchain[1];
  assign left_px    = (col == '0) ? 1'b0 : left[0];
  assign eroded     = mid & {mid[6:0], right[7]} & {left_px, mid[7:1]} & up & pixel_byte;

  // ---------------------------------------------------------------------------
  // Results of one request.
  // First: a zero byte on row 0 unless it is the last row, or the eroded byte one row up from row 2 on.
  // Second: on the last row, a zero byte for the current position.
  // ---------------------------------------------------------------------------
  always_comb begin
    pair.a_valid       = accept && (((row == '0) && !last_row) || (row > RW'(1)));
    pair.a.eroded_byte = (row == '0) ? '0 : eroded;
    pair.a.out_row     = (row == '0) ? '0 : ROW_OUT_W'(row - RW'(1));
    pair.a.out_col     = COL_OUT_W'(col);
    pair.a.run_last    = !last_row;
    pair.a.frame_done  = 1'b0;
    pair.b_valid       = accept && last_row;
    pair.b.eroded_byte = '0;
    pair.b.out_row     = ROW_OUT_W'(row);
    pair.b.out_col     = COL_OUT_W'(col);
    pair.b.run_last    = 1'b1;
    pair.b.frame_done  = at_row_end;
  end

  // ---------------------------------------------------------------------------
  // Position: advance on each request, wrap at row and frame end.
  // Any config write restarts the frame; the line buffers are kept.
  // ---------------------------------------------------------------------------
  always_comb begin
    col_next  = col;
    row_next  = row;
    left_next = left;
    if (cfg_we) begin
      col_next  = '0;
      row_next  = '0;
      left_next = '0;
    end else if (accept) begin
      if (at_row_end) begin
        col_next  = '0;
        left_next = '0;
        row_next  = last_row ? '0 : row + RW'(1);
      end else begin
        col_next  = col + CW'(1);
        left_next = mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      left <= '0;
    end else begin
      col  <= col_next;
      row  <= row_next;
      left <= left_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue: parts the request side from a stalled result port.
  // ---------------------------------------------------------------------------
  pbce_oq u_oq (
    .clk   (clk),
    .rst   (rst),
    .push  (pair),
    .stall (result_stall),
    .head  (head),
    .valid (result_valid),
    .room  (room)
  );

  assign eroded_byte = head.eroded_byte;
  assign out_row     = head.out_row;
  assign out_col     = head.out_col;
  assign run_last    = head.run_last;
  assign frame_done  = head.frame_done;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `PBCE_ASSERT_NOW(a_pos_in_range, 1'b1, (col <= w_m1) && (row <= h_m1), "position outside frame")
  `PBCE_ASSERT_NOW(a_done_is_last, result_valid && frame_done, run_last, "frame_done without run_last")
  `PBCE_ASSERT_NEXT(a_result_follows, pair.a_valid || pair.b_valid, result_valid, "result lost")
  `PBCE_ASSERT_NEXT(a_frame_wrap, accept && last_row && at_row_end, (row == '0) && (col == '0), "no frame wrap")

endmodule

// ===== sv/pbce_cell.sv =====
// One byte cell of a variable-length line buffer shift chain.
// No package dependencies.
`timescale 1ns / 1ps

module pbce_cell (
  input  logic       clk,
  input  logic       shift,
  input  logic       entry,
  input  logic [7:0] din,
  input  logic [7:0] nbr,
  output logic [7:0] q
);

  // The entry cell takes fresh data, every other cell takes its neighbor's byte.
  always_ff @(posedge clk) begin
    if (shift) begin
      q <= entry ? din : nbr;
    end
  end

endmodule

// ===== sv/pbce_oq.sv =====
// Small result queue: up to two pushes and one pop per cycle.
// Depends on pbce_pkg (res_t, pair_t, queue depth).
`timescale 1ns / 1ps

module pbce_oq import pbce_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  pair_t push,
  input  logic  stall,
  output res_t  head,
  output logic  valid,
  output logic  room
);

  localparam int CNTW = OQ_PW + 1;

  res_t             entries [OQ_DEPTH];
  logic [OQ_PW-1:0] wp;
  logic [OQ_PW-1:0] wp_next;
  logic [OQ_PW-1:0] rp;
  logic [OQ_PW-1:0] rp_next;
  logic [CNTW-1:0]  count;
  logic [CNTW-1:0]  count_next;
  logic             pop;
  logic             any_push;
  logic             both_push;
  res_t             first;

  assign valid     = (count != '0);
  assign room      = (count <= CNTW'(OQ_DEPTH - 2));
  assign head      = entries[rp];
  assign pop       = valid && !stall;
  assign any_push  = push.a_valid || push.b_valid;
  assign both_push = push.a_valid && push.b_valid;
  assign first     = push.a_valid ? push.a : push.b;

  always_comb begin
    wp_next    = wp + OQ_PW'(push.a_valid) + OQ_PW'(push.b_valid);
    rp_next    = pop ? rp + OQ_PW'(1) : rp;
    count_next = count + CNTW'(push.a_valid) + CNTW'(push.b_valid) - CNTW'(pop);
  end

  always_ff @(posedge clk) begin
    if (any_push) begin
      entries[wp] <= first;
    end
    if (both_push) begin
      entries[wp + OQ_PW'(1)] <= push.b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp_next;
      rp    <= rp_next;
      count <= count_next;
    end
  end

endmodule
